// File: hdl/ccdn_pkg.sv
`default_nettype none

package ccdn_pkg;

	// calendar span searched in days-to-date mode
	localparam int FIRST_YEAR   = 1970;
	localparam int YEAR_LIMIT   = 3000;
	localparam int EPOCH_OFFSET = 719163;

	// year register width, candidate width, number of search cells
	localparam int YW    = $clog2(YEAR_LIMIT);
	localparam int CW    = YW + 1;
	localparam int NSTEP = $clog2(YEAR_LIMIT - FIRST_YEAR);

	// internal day arithmetic width, argument width
	localparam int DW = 25;
	localparam int AW = 23;

	// reciprocal of 100, exact for values below 43690
	localparam int RECIP_100   = 5243;
	localparam int RECIP_SHIFT = 19;

	function automatic int year_days(int y);
		int p;
		p = y - 1;
		return 365 * p + p / 4 - p / 100 + p / 400 + 1 - EPOCH_OFFSET;
	endfunction

	localparam logic signed [DW-1:0] LO_DAYS    = DW'(year_days(FIRST_YEAR));
	localparam logic signed [DW-1:0] HI_DAYS    = DW'(year_days(YEAR_LIMIT));
	localparam logic signed [DW-1:0] EPOCH_DAYS = DW'(EPOCH_OFFSET);
	localparam logic signed [DW-1:0] EPOCH_JAN1 = DW'(EPOCH_OFFSET - 1);
	localparam logic signed [DW-1:0] YEAR0_BASE = -DW'(366);
	localparam logic signed [DW-1:0] DAYS_MAX   = DW'(4194303);
	localparam logic signed [DW-1:0] DAYS_MIN   = -DW'(4194304);

	// item moving along the search chain
	typedef struct packed {
		logic                 func;
		logic                 oor;
		logic [AW-1:0]        arg;
		logic [YW-1:0]        yr;
		logic signed [DW-1:0] base;
	} item_t;

	// one result item
	typedef struct packed {
		logic [22:0] days;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        oor;
	} res_t;

	// days before the first of month idx+1 in a common year
	function automatic logic [8:0] month_start(logic [3:0] idx);
		logic [8:0] v;
		case (idx)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd31;
			4'd2:    v = 9'd59;
			4'd3:    v = 9'd90;
			4'd4:    v = 9'd120;
			4'd5:    v = 9'd151;
			4'd6:    v = 9'd181;
			4'd7:    v = 9'd212;
			4'd8:    v = 9'd243;
			4'd9:    v = 9'd273;
			4'd10:   v = 9'd304;
			4'd11:   v = 9'd334;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] div100(logic [15:0] v);
		logic [31:0] prod;
		prod = {16'd0, v} * 32'(RECIP_100);
		return 16'(prod >> RECIP_SHIFT);
	endfunction

endpackage

`default_nettype wire

// File: hdl/ccdn_ifs.sv
`default_nettype none

interface ccdn_req_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [13:0]        year;
	logic [3:0]         month;
	logic [4:0]         day;
	logic signed [22:0] day_number;

	modport source (output valid, func, year, month, day, day_number, input ready);
	modport sink   (input valid, func, year, month, day, day_number, output ready);
endinterface

interface ccdn_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [22:0] result_days;
	logic [11:0]        result_year;
	logic [3:0]         result_month;
	logic [4:0]         result_day;
	logic               out_of_range;

	modport source (output valid, result_days, result_year, result_month, result_day,
		out_of_range, input ready);
	modport sink   (input valid, result_days, result_year, result_month, result_day,
		out_of_range, output ready);
endinterface

`default_nettype wire

// File: hdl/ccdn_search_cell.sv
`default_nettype none

// one bisection step of the year search, two stages
module ccdn_search_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [ccdn_pkg::CW-1:0]    step,
	input  logic                       left_valid,
	input  ccdn_pkg::item_t            left_item,
	output logic                       right_valid,
	output ccdn_pkg::item_t            right_item
);
	localparam int CW = ccdn_pkg::CW;
	localparam int YW = ccdn_pkg::YW;
	localparam int DW = ccdn_pkg::DW;
	localparam int PW = CW + 9;

	logic [CW-1:0]        cand, p;
	logic [PW-1:0]        p365;
	logic [15:0]          q;
	logic                 valid_s1;
	ccdn_pkg::item_t      item_s1;
	logic [CW-1:0]        cand_s1, p_s1, q_s1;
	logic [PW-1:0]        p365_s1;
	logic                 span_s1;
	logic signed [DW-1:0] days, dn;
	logic                 take;
	ccdn_pkg::item_t      item_nx;

	assign cand = CW'(left_item.yr) + step;
	assign p    = cand - CW'(1);
	assign p365 = PW'(p) * PW'(365);
	assign q    = ccdn_pkg::div100(16'(p));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			right_valid <= 1'b0;
		end else if (en) begin
			valid_s1    <= left_valid;
			right_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= left_item;
			cand_s1 <= cand;
			p_s1    <= p;
			q_s1    <= q[CW-1:0];
			p365_s1 <= p365;
			span_s1 <= cand < CW'(ccdn_pkg::YEAR_LIMIT);
		end
	end

	// day number of jan 1 of the candidate year
	assign days = $signed(DW'(p365_s1)) + $signed(DW'(p_s1 >> 2)) - $signed(DW'(q_s1))
		+ $signed(DW'(q_s1 >> 2)) - ccdn_pkg::EPOCH_JAN1;
	assign dn   = DW'($signed(item_s1.arg));
	assign take = span_s1 && (dn >= days);

	always_comb begin
		item_nx = item_s1;
		if (take) begin
			item_nx.yr   = cand_s1[YW-1:0];
			item_nx.base = days;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			right_item <= item_nx;
		end
	end

endmodule

`default_nettype wire

// File: hdl/ccdn_date_path.sv
`default_nettype none

// date to day number, three stages
module ccdn_date_path (
	input  logic             clk,
	input  logic             en,
	input  ccdn_pkg::item_t  item,
	output ccdn_pkg::res_t   res
);
	localparam int DW = ccdn_pkg::DW;

	logic [13:0]          y, p;
	logic [3:0]           m, mi;
	logic [4:0]           d;
	logic [15:0]          q;
	logic                 y0_s1, late_s1;
	logic [13:0]          p_s1, q_s1;
	logic [22:0]          p365_s1;
	logic [9:0]           ms_s1;
	logic [13:0]          r100;
	logic                 c100, lp;
	logic signed [DW-1:0] base, total, total_s2;

	assign y  = item.arg[22:9];
	assign m  = item.arg[8:5];
	assign d  = item.arg[4:0];
	assign p  = y - 14'd1;
	assign q  = ccdn_pkg::div100({2'b00, p});
	// month zero reads as january, above twelve as december
	assign mi = (m == 4'd0) ? 4'd1 : ((m > 4'd12) ? 4'd12 : m);

	always_ff @(posedge clk) begin
		if (en) begin
			y0_s1   <= (y == 14'd0);
			late_s1 <= (mi > 4'd2);
			p_s1    <= p;
			q_s1    <= q[13:0];
			p365_s1 <= 23'(p) * 23'd365;
			ms_s1   <= 10'(ccdn_pkg::month_start(mi - 4'd1)) + 10'(d);
		end
	end

	// leap test of y = p + 1
	assign r100 = p_s1 - 14'(q_s1 * 14'd100);
	assign c100 = (r100 == 14'd99);
	assign lp   = y0_s1 || ((p_s1[1:0] == 2'd3) && !c100) || (c100 && (q_s1[1:0] == 2'd3));
	assign base = y0_s1 ? ccdn_pkg::YEAR0_BASE
		: $signed(DW'(p365_s1)) + $signed(DW'(p_s1 >> 2)) - $signed(DW'(q_s1))
		+ $signed(DW'(q_s1 >> 2));
	assign total = base + $signed(DW'(ms_s1)) + $signed(DW'(lp && late_s1))
		- ccdn_pkg::EPOCH_DAYS;

	always_ff @(posedge clk) begin
		if (en) begin
			total_s2 <= total;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.year  <= '0;
			res.month <= '0;
			res.day   <= '0;
			if (total_s2 > ccdn_pkg::DAYS_MAX) begin
				res.days <= 23'(ccdn_pkg::DAYS_MAX);
				res.oor  <= 1'b1;
			end else if (total_s2 < ccdn_pkg::DAYS_MIN) begin
				res.days <= 23'(ccdn_pkg::DAYS_MIN);
				res.oor  <= 1'b1;
			end else begin
				res.days <= total_s2[22:0];
				res.oor  <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/ccdn_year_split.sv
`default_nettype none

// found year to month and day, three stages
module ccdn_year_split (
	input  logic             clk,
	input  logic             en,
	input  ccdn_pkg::item_t  item,
	output ccdn_pkg::res_t   res
);
	localparam int YW = ccdn_pkg::YW;
	localparam int DW = ccdn_pkg::DW;

	logic signed [DW-1:0] rem;
	logic [15:0]          q;
	logic [8:0]           rem_s1, rem_s2;
	logic [YW-1:0]        yr_s1, yr_s2, q_s1;
	logic                 oor_s1, oor_s2;
	logic                 c100, lp, lp_s2;
	logic [3:0]           cnt, mon_s2;
	logic                 adj;
	logic [8:0]           dd;

	assign rem = DW'($signed(item.arg)) - $signed(item.base);
	assign q   = ccdn_pkg::div100(16'(item.yr));

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= rem[8:0];
			yr_s1  <= item.yr;
			q_s1   <= q[YW-1:0];
			oor_s1 <= item.oor;
		end
	end

	assign c100 = (16'(yr_s1) == 16'(16'(q_s1) * 16'd100));
	assign lp   = ((yr_s1[1:0] == 2'd0) && !c100) || (c100 && (q_s1[1:0] == 2'd0));

	// month boundaries passed, thresholds rise so a count gives the month
	always_comb begin
		logic [9:0] thr;
		cnt = 4'd0;
		for (int i = 1; i < 12; i++) begin
			thr = 10'(ccdn_pkg::month_start(4'(i))) + 10'(lp && (i >= 2));
			if (10'(rem_s1) >= thr) begin
				cnt = cnt + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2 <= rem_s1;
			yr_s2  <= yr_s1;
			oor_s2 <= oor_s1;
			lp_s2  <= lp;
			mon_s2 <= cnt + 4'd1;
		end
	end

	assign adj = lp_s2 && (mon_s2 > 4'd2);
	assign dd  = rem_s2 - ccdn_pkg::month_start(mon_s2 - 4'd1) - 9'(adj) + 9'd1;

	always_ff @(posedge clk) begin
		if (en) begin
			res.days <= '0;
			res.oor  <= oor_s2;
			if (oor_s2) begin
				res.year  <= '0;
				res.month <= '0;
				res.day   <= '0;
			end else begin
				res.year  <= 12'(yr_s2);
				res.month <= mon_s2;
				res.day   <= dd[4:0];
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/civil_date_day_number_converter.sv
// Converts between proleptic Gregorian dates and day numbers counted from
// 1970-01-01, one item per clock cycle in either direction while no result
// waits in the skid register; func selects the direction per item. The year
// search covers 1970 to 2999 with a chain of NSTEP two-stage cells, one
// bisection step each, followed by three stages that split the year into
// month and day. Date-to-days items travel the same chain and are converted
// in three stages alongside the split, so results leave in input order. A
// skid register at the output parks one result that is not taken, and the
// input closes while it holds one. Day numbers outside the searchable
// span, and date results that do not fit 23 signed bits, raise out_of_range.

`default_nettype none

module civil_date_day_number_converter (
	input  logic         clk,
	input  logic         arst_n,
	ccdn_req_if.sink     request,
	ccdn_rsp_if.source   response
);
	localparam int NSTEP = ccdn_pkg::NSTEP;
	localparam int CW    = ccdn_pkg::CW;
	localparam int YW    = ccdn_pkg::YW;
	localparam int DW    = ccdn_pkg::DW;

	// global advance: the whole pipe moves unless the skid holds an item
	logic                 adv;
	logic                 skid_valid_q;
	ccdn_pkg::res_t       skid_q;
	ccdn_pkg::res_t       res_date, res_split, res_cur;

	logic signed [DW-1:0] dn_ext;
	logic                 dn_oor;
	ccdn_pkg::item_t      item_in;
	logic                 in_valid_s1;
	ccdn_pkg::item_t      in_item_s1;

	ccdn_pkg::item_t      chain_item  [NSTEP+1];
	logic                 chain_valid [NSTEP+1];

	logic                 tail_valid_s1, tail_valid_s2, tail_valid_s3;
	logic                 tail_func_s1, tail_func_s2, tail_func_s3;

	assign adv           = !skid_valid_q;
	assign request.ready = adv;

	// span check on the raw day number
	assign dn_ext = DW'($signed(request.day_number));
	assign dn_oor = (dn_ext < ccdn_pkg::LO_DAYS) || (dn_ext >= ccdn_pkg::HI_DAYS);

	// the argument slot carries the day number or the packed date
	always_comb begin
		item_in.func = request.func;
		item_in.oor  = dn_oor;
		item_in.arg  = request.func ? request.day_number
			: {request.year, request.month, request.day};
		item_in.yr   = YW'(ccdn_pkg::FIRST_YEAR);
		item_in.base = ccdn_pkg::LO_DAYS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (adv) begin
			in_valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_item_s1 <= item_in;
		end
	end

	assign chain_item[0]  = in_item_s1;
	assign chain_valid[0] = in_valid_s1;

	// search chain, step halves from cell to cell
	for (genvar k = 0; k < NSTEP; k++) begin : g_cell
		localparam int SH = NSTEP - 1 - k;
		logic [CW-1:0] step_k;
		assign step_k = {{(CW-1){1'b0}}, 1'b1} << SH;

		ccdn_search_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (adv),
			.step        (step_k),
			.left_valid  (chain_valid[k]),
			.left_item   (chain_item[k]),
			.right_valid (chain_valid[k+1]),
			.right_item  (chain_item[k+1])
		);
	end

	ccdn_date_path u_date (
		.clk  (clk),
		.en   (adv),
		.item (chain_item[NSTEP]),
		.res  (res_date)
	);

	ccdn_year_split u_split (
		.clk  (clk),
		.en   (adv),
		.item (chain_item[NSTEP]),
		.res  (res_split)
	);

	// valid and direction follow the three tail stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_valid_s1 <= 1'b0;
			tail_valid_s2 <= 1'b0;
			tail_valid_s3 <= 1'b0;
		end else if (adv) begin
			tail_valid_s1 <= chain_valid[NSTEP];
			tail_valid_s2 <= tail_valid_s1;
			tail_valid_s3 <= tail_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tail_func_s1 <= chain_item[NSTEP].func;
			tail_func_s2 <= tail_func_s1;
			tail_func_s3 <= tail_func_s2;
		end
	end

	assign res_cur = tail_func_s3 ? res_split : res_date;

	// skid: park the last stage's item when it is not taken and the pipe moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (adv && tail_valid_s3 && !response.ready) begin
			skid_valid_q <= 1'b1;
		end else if (skid_valid_q && response.ready) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skid_q <= res_cur;
		end
	end

	// the parked item is older, it goes first
	assign response.valid        = skid_valid_q || tail_valid_s3;
	assign response.result_days  = skid_valid_q ? skid_q.days  : res_cur.days;
	assign response.result_year  = skid_valid_q ? skid_q.year  : res_cur.year;
	assign response.result_month = skid_valid_q ? skid_q.month : res_cur.month;
	assign response.result_day   = skid_valid_q ? skid_q.day   : res_cur.day;
	assign response.out_of_range = skid_valid_q ? skid_q.oor   : res_cur.oor;

endmodule

`default_nettype wire

// File: hdl/ccdn_checker.sv
`default_nettype none

module ccdn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [22:0] rsp_days,
	input logic [11:0] rsp_year,
	input logic [3:0]  rsp_month,
	input logic [4:0]  rsp_day,
	input logic        rsp_oor
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
		&& $stable({rsp_days, rsp_year, rsp_month, rsp_day, rsp_oor}))
		else $error("stalled result changed");

	// input closes only while a parked result is shown
	a_block_has_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid)
		else $error("input closed with no result pending");

	// input stays closed until the parked result is taken
	a_block_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready && !rsp_ready |=> !req_ready)
		else $error("input reopened before result was taken");

	// a found year comes with a real month and day and nothing else
	a_date_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_year != 12'd0) |-> (rsp_days == 23'd0) && !rsp_oor
		&& (rsp_month >= 4'd1) && (rsp_month <= 4'd12) && (rsp_day >= 5'd1))
		else $error("malformed date result");

endmodule

bind civil_date_day_number_converter ccdn_checker u_ccdn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (request.ready),
	.rsp_valid (response.valid),
	.rsp_ready (response.ready),
	.rsp_days  (response.result_days),
	.rsp_year  (response.result_year),
	.rsp_month (response.result_month),
	.rsp_day   (response.result_day),
	.rsp_oor   (response.out_of_range)
);

`default_nettype wire
